// ===== rtl/core/sha1bsh_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the sha-1 byte stream hasher
package sha1bsh_pkg;

	typedef enum logic [1:0] {
		ACT_ABSORB  = 2'd0,
		ACT_FINISH  = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef logic [4:0][31:0] chain_t;

	typedef struct packed {
		logic start;
		logic init;
	} rnd_ctl_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam chain_t CHAIN_INIT = {IV4, IV3, IV2, IV1, IV0};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ===== rtl/core/sha1_byte_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// top level of the sha-1 byte stream hasher: byte packing, padding, digest output
//
// input channel s_*: one beat per item; s_tuser[1:0] is the action (absorb, finish,
// restart), s_tdata[7:0] the message byte for an absorb.
// output channel m_*: one beat per digest word, m_tdata the word (most significant
// word first), m_tuser[2:0] its index, m_tlast high on the fifth word.
// an absorb packs its byte into the block buffer; the byte that completes a 64-byte
// block starts the compression (80 rounds, one per cycle, plus the chaining add),
// during which no input beat is taken. the rounds use the single read port of the
// block buffer for the first 16 schedule words.
// a finish writes the padding and length one byte per cycle into the block buffer
// (in a second 64-byte block as well when the tail does not fit), then compresses
// and sends five beats. restart and reset return the hasher to the initial state.
// a stalled receiver holds the output register; input beats are taken again as
// soon as the last digest word sits in the output register.
module sha1_byte_stream_hasher_core
	import sha1bsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_PAD,
		T_HASH,
		T_EMIT
	} tstate_t;

	tstate_t     state_q, after_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [23:0] pw_q;
	logic        pad_first_q, extra_q;
	logic [2:0]  idx_q;
	logic        m_tvalid_q, m_tlast_q;
	logic [31:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	action_t     act;
	logic        s_fire, byte_we, out_load;
	logic [7:0]  byte_val, pad_byte, len_byte;
	rnd_ctl_t    ctl;
	logic        done;
	chain_t      chain;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;

	assign act      = action_t'(s_tuser);
	assign s_tready = (state_q == T_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});
	assign pad_byte = pad_first_q ? PAD_MARK :
		((!extra_q && fill_q >= 6'd56) ? len_byte : 8'h00);

	assign byte_we  = (s_fire && act == ACT_ABSORB) || (state_q == T_PAD);
	assign byte_val = (state_q == T_PAD) ? pad_byte : s_tdata;
	assign out_load = (state_q == T_EMIT) && (!m_tvalid_q || m_tready);

	assign ctl.start = byte_we && (fill_q == 6'd63);
	assign ctl.init  = (s_fire && act == ACT_RESTART) || (out_load && idx_q == 3'd4);

	sha1bsh_bmem u_bmem (
		.clk     (clk),
		.wr_en   (byte_we && fill_q[1:0] == 2'b11),
		.wr_addr (fill_q[5:2]),
		.wr_data ({pw_q, byte_val}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha1bsh_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.done    (done),
		.chain   (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			after_q     <= T_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			pw_q        <= '0;
			pad_first_q <= 1'b0;
			extra_q     <= 1'b0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			if (byte_we) begin
				pw_q   <= {pw_q[15:0], byte_val};
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				T_IDLE: begin
					if (s_fire) begin
						unique case (act)
							ACT_ABSORB: begin
								bits_q <= bits_q + 64'd8;
								if (fill_q == 6'd63) begin
									state_q <= T_HASH;
									after_q <= T_IDLE;
								end
							end
							ACT_FINISH: begin
								state_q     <= T_PAD;
								pad_first_q <= 1'b1;
								extra_q     <= 1'b0;
							end
							ACT_RESTART: begin
								fill_q <= '0;
								bits_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				T_PAD: begin
					pad_first_q <= 1'b0;
					if (fill_q == 6'd63) begin
						extra_q <= 1'b0;
						state_q <= T_HASH;
						after_q <= (!pad_first_q && !extra_q) ? T_EMIT : T_PAD;
						idx_q   <= '0;
					end else if (pad_first_q && fill_q >= 6'd56) begin
						extra_q <= 1'b1;
					end
				end
				T_HASH: begin
					if (done) begin
						state_q <= after_q;
					end
				end
				T_EMIT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= chain[idx_q];
						m_tuser_q  <= idx_q;
						m_tlast_q  <= (idx_q == 3'd4);
						idx_q      <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							state_q <= T_IDLE;
							bits_q  <= '0;
							fill_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/core/sha1bsh_bmem.sv =====
`timescale 1ns / 1ps
// 16 x 32 block buffer, one write port, one registered read port
module sha1bsh_bmem
	import sha1bsh_pkg::*;
(
	input  logic        clk,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/sha1bsh_round.sv =====
`timescale 1ns / 1ps
// sha-1 compression: one round per cycle, message schedule window, chaining words
module sha1bsh_round
	import sha1bsh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rnd_ctl_t    ctl,
	input  logic [31:0] rd_data,
	output logic [3:0]  rd_addr,
	output logic        done,
	output chain_t      chain
);

	typedef enum logic [1:0] {
		R_IDLE,
		R_RUN,
		R_ADD
	} rstate_t;

	rstate_t     state_q;
	logic [6:0]  rnd_q;
	logic        done_q;
	chain_t      h_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];

	logic [31:0] w_new, w_cur, f, k, t;

	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign w_cur = (rnd_q < 7'd16) ? rd_data : w_new;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;

	assign rd_addr = (state_q == R_RUN) ? 4'(rnd_q + 7'd1) : 4'd0;
	assign done    = done_q;
	assign chain   = h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			h_q     <= CHAIN_INIT;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (ctl.init) begin
						h_q <= CHAIN_INIT;
					end
					if (ctl.start) begin
						state_q <= R_RUN;
						rnd_q   <= '0;
					end
				end
				R_RUN: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) begin
						state_q <= R_ADD;
					end
				end
				R_ADD: begin
					h_q[0]  <= h_q[0] + a_q;
					h_q[1]  <= h_q[1] + b_q;
					h_q[2]  <= h_q[2] + c_q;
					h_q[3]  <= h_q[3] + d_q;
					h_q[4]  <= h_q[4] + e_q;
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && state_q == R_IDLE) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == R_RUN) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_cur;
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking stream bench for the sha-1 byte stream hasher core
module testbench;
	import sha1bsh_pkg::*;

	localparam int IDLE_LIMIT    = 6000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 700;
	localparam int RANDOM_BEATS  = 350;
	localparam int MIN_MESSAGES  = 10;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	class sha1_digest_board;
		logic [31:0]  chain [5];
		logic [7:0]   msg_block [64];
		int unsigned  fill;
		logic [63:0]  bit_count;
		digest_beat_t digest_q [$];
		int           errors;
		int           beats;
		int           digests;
		int           words;

		function new();
			errors = 0;
			beats = 0;
			digests = 0;
			words = 0;
			clear_state();
		endfunction

		function void clear_state();
			chain[0] = IV0;
			chain[1] = IV1;
			chain[2] = IV2;
			chain[3] = IV3;
			chain[4] = IV4;
			foreach (msg_block[i]) msg_block[i] = 8'h00;
			fill = 0;
			bit_count = 64'd0;
		endfunction

		function void compress();
			logic [31:0] sched [80];
			logic [31:0] a, b, c, d, e, f, k, t;
			int r;
			for (r = 0; r < 16; r++)
				sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
			for (r = 16; r < 80; r++) begin
				t = sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16];
				sched[r] = {t[30:0], t[31]};
			end
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = K0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = K1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K2;
				end else begin
					f = b ^ c ^ d;
					k = K3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + sched[r];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void note_input(action_t act, logic [7:0] data_byte);
			digest_beat_t beat;
			int i;
			beats++;
			case (act)
				ACT_ABSORB: begin
					bit_count += 64'd8;
					msg_block[fill] = data_byte;
					fill++;
					if (fill == 64) begin
						compress();
						fill = 0;
					end
				end
				ACT_RESTART: clear_state();
				ACT_FINISH: begin
					msg_block[fill] = PAD_MARK;
					fill++;
					if (fill > 56) begin
						while (fill < 64) begin
							msg_block[fill] = 8'h00;
							fill++;
						end
						compress();
						fill = 0;
					end
					while (fill < 56) begin
						msg_block[fill] = 8'h00;
						fill++;
					end
					for (i = 7; i >= 0; i--) begin
						msg_block[fill] = bit_count[8*i +: 8];
						fill++;
					end
					compress();
					for (i = 0; i < 5; i++) begin
						beat.word = chain[i];
						beat.idx = 3'(i);
						beat.last = (i == 4);
						digest_q.push_back(beat);
					end
					digests++;
					clear_state();
				end
				default: ;
			endcase
		endfunction

		function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
			digest_beat_t want;
			words++;
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, actual %h idx %0d last %0b",
					$time, word, idx, last);
				return;
			end
			want = digest_q.pop_front();
			if (word !== want.word) begin
				errors++;
				$display("%0t: digest word %0d: expected %h, actual %h",
					$time, want.idx, want.word, word);
			end
			if (idx !== want.idx) begin
				errors++;
				$display("%0t: word index: expected %0d, actual %0d", $time, want.idx, idx);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last flag on word %0d: expected %0b, actual %0b",
					$time, want.idx, want.last, last);
			end
		endfunction

		function int pending();
			return digest_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	bit               no_idle = 1'b0;
	bit               hold_req = 1'b0;
	int               stall_count = 0;
	sha1_digest_board board = new();

	sha1_byte_stream_hasher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_beat(input action_t act, input logic [7:0] data_byte);
		while (!no_idle && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= data_byte;
		do @(posedge clk); while (!s_tready);
		board.note_input(act, data_byte);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_word(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int len;
		int j;
		int msgs;
		int items;
		int longest;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = ACT_ABSORB;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then a short text message
		send_beat(ACT_FINISH, 8'h00);
		send_beat(ACT_ABSORB, 8'h61);
		send_beat(ACT_ABSORB, 8'h62);
		send_beat(ACT_ABSORB, 8'h63);
		send_beat(ACT_FINISH, 8'hFF);
		// discarded message and unused action code
		send_beat(ACT_ABSORB, 8'hFF);
		send_beat(ACT_ABSORB, 8'h00);
		send_beat(ACT_NONE, 8'hFF);
		send_beat(ACT_RESTART, 8'hAA);
		send_beat(ACT_FINISH, 8'h55);
		// byte extremes
		send_beat(ACT_NONE, 8'h00);
		send_beat(ACT_ABSORB, 8'hFF);
		send_beat(ACT_ABSORB, 8'h00);
		send_beat(ACT_ABSORB, 8'h80);
		send_beat(ACT_ABSORB, 8'h7F);
		send_beat(ACT_FINISH, 8'h00);
		wait_drained();

		msgs = 0;
		items = 0;
		longest = 0;
		while (items < RANDOM_BEATS || msgs < MIN_MESSAGES) begin
			no_idle = (msgs >= 6 && msgs < 9);
			if (msgs == 3)
				hold_req = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(0, 24);
				6, 7: begin
					case ($urandom_range(0, 5))
						0: len = 55;
						1: len = 56;
						2: len = 63;
						3: len = 64;
						4: len = 119;
						default: len = 120;
					endcase
				end
				default: len = $urandom_range(0, 140);
			endcase
			if (len > longest)
				longest = len;
			for (j = 0; j < len; j++) begin
				if ($urandom_range(0, 39) == 0)
					send_beat(ACT_NONE, 8'($urandom));
				send_beat(ACT_ABSORB, 8'($urandom));
			end
			if ($urandom_range(0, 9) == 0)
				send_beat(ACT_RESTART, 8'($urandom));
			else
				send_beat(ACT_FINISH, 8'($urandom));
			items += len + 1;
			if (msgs == 4)
				wait_drained();
			msgs++;
		end
		no_idle = 1'b0;
		wait_drained();

		$display("%0d input beats taken, %0d digests predicted, %0d digest words checked",
			board.beats, board.digests, board.words);
		$display("%0d random messages up to %0d bytes, one output hold of %0d cycles",
			msgs, longest, HOLD_CYCLES);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
